// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: condition does not hold");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/ple_pkg.sv
`default_nettype none

package ple_pkg;

  // List geometry.
  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 16;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Field widths of the command and result transactions.
  localparam int MODE_W   = 3;
  localparam int POS_W    = 7;
  localparam int WORD_W   = 16;
  localparam int STATUS_W = 2;

  typedef logic [DATA_WIDTH-1:0] word_t;

  // Command codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_INS_POS  = 3'd0,
    MODE_INS_HEAD = 3'd1,
    MODE_INS_TAIL = 3'd2,
    MODE_REM_POS  = 3'd3,
    MODE_REM_HEAD = 3'd4,
    MODE_REM_TAIL = 3'd5
  } mode_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_BADPOS = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic {
    ST_WAIT = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the incoming command
    logic exec;  // apply the held command and load the result register
  } ple_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/ple_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module ple_ctrl
  import ple_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  output ple_cmd_t      cmd
);

  state_e state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_WAIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_WAIT: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // The result register must be empty or draining this cycle.
        if (!out_valid_r || out_tready) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      default: begin
        state_nxt = ST_WAIT;
      end
    endcase
  end

  // A fresh result takes priority over the one being drained.
  always_comb begin
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  // A result is never overwritten while it is still waiting.
  `ASSERT_IMPLIES(a_no_overwrite, clk, rst_n, cmd.exec, !out_valid_r || out_tready)
  // Load and execute never happen in the same cycle.
  `ASSERT_ALWAYS(a_cmd_exclusive, clk, rst_n, !(cmd.load && cmd.exec))

endmodule

`default_nettype wire

// File: rtl/core/ple_datapath.sv
`default_nettype none

`include "assert_macros.svh"

module ple_datapath
  import ple_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ple_cmd_t            cmd,
  input  wire logic [MODE_W-1:0]   mode,
  input  wire logic [POS_W-1:0]    position,
  input  wire logic [WORD_W-1:0]   payload,
  output logic [STATUS_W-1:0]      status,
  output logic [WORD_W-1:0]        removed_value,
  output logic [CNT_W-1:0]         element_count
);

  // Held command.
  logic [MODE_W-1:0]   mode_r;
  logic [POS_W-1:0]    pos_r;
  word_t               payload_r;

  // List storage: a chain of cells that shift in parallel.
  word_t               cells_r   [CAPACITY];
  word_t               cells_nxt [CAPACITY];
  logic [CNT_W-1:0]    size_r, size_nxt;

  // Result register.
  status_e             status_r;
  logic [WORD_W-1:0]   removed_r;
  logic [CNT_W-1:0]    count_r;

  // Decode.
  logic                is_ins, is_rem, do_ins, do_rem;
  logic [POS_W-1:0]    at;
  status_e             st;
  word_t               rd_word;

  // Capture the command when the controller accepts it.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= mode;
      pos_r     <= position;
      payload_r <= payload[DATA_WIDTH-1:0];
    end
  end

  // Resolve the target position for each command.
  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    at     = '0;
    case (mode_r)
      MODE_INS_POS: begin
        is_ins = 1'b1;
        at     = pos_r;
      end
      MODE_INS_HEAD: begin
        is_ins = 1'b1;
      end
      MODE_INS_TAIL: begin
        is_ins = 1'b1;
        at     = POS_W'(size_r);
      end
      MODE_REM_POS: begin
        is_rem = 1'b1;
        at     = pos_r;
      end
      MODE_REM_HEAD: begin
        is_rem = 1'b1;
      end
      MODE_REM_TAIL: begin
        is_rem = 1'b1;
        at     = POS_W'(size_r) - POS_W'(1);
      end
      default: begin
        is_ins = 1'b0;
      end
    endcase
  end

  // Status checks; a position error on insert wins over a full list,
  // an empty list on remove wins over a position error.
  always_comb begin
    st = STAT_OK;
    if (is_ins) begin
      if (at > POS_W'(size_r)) begin
        st = STAT_BADPOS;
      end else if (size_r >= CNT_W'(CAPACITY)) begin
        st = STAT_FULL;
      end
    end else if (is_rem) begin
      if (size_r == '0) begin
        st = STAT_EMPTY;
      end else if (at >= POS_W'(size_r)) begin
        st = STAT_BADPOS;
      end
    end
  end

  assign do_ins  = is_ins && (st == STAT_OK);
  assign do_rem  = is_rem && (st == STAT_OK);
  assign rd_word = cells_r[at[IDX_W-1:0]];

  // Next cell contents: shift up behind an insert, down behind a removal.
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      cells_nxt[k] = cells_r[k];
    end
    for (int k = 1; k < CAPACITY; k++) begin
      if (do_ins && (POS_W'(k) > at)) begin
        cells_nxt[k] = cells_r[k-1];
      end
    end
    for (int k = 0; k < CAPACITY - 1; k++) begin
      if (do_rem && (POS_W'(k) >= at)) begin
        cells_nxt[k] = cells_r[k+1];
      end
    end
    for (int k = 0; k < CAPACITY; k++) begin
      if (do_ins && (POS_W'(k) == at)) begin
        cells_nxt[k] = payload_r;
      end
    end
  end

  // Element count after the command.
  always_comb begin
    size_nxt = size_r;
    if (do_ins) begin
      size_nxt = size_r + CNT_W'(1);
    end else if (do_rem) begin
      size_nxt = size_r - CNT_W'(1);
    end
  end

  // Cell chain, no reset: entries at or above the count are never read.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      for (int k = 0; k < CAPACITY; k++) begin
        cells_r[k] <= cells_nxt[k];
      end
    end
  end

  // Element count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '0;
    end else if (cmd.exec) begin
      size_r <= size_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r  <= st;
      removed_r <= do_rem ? WORD_W'(rd_word) : '0;
      count_r   <= size_nxt;
    end
  end

  assign status        = status_r;
  assign removed_value = removed_r;
  assign element_count = count_r;

  // The count never exceeds the capacity.
  `ASSERT_ALWAYS(a_size_bound, clk, rst_n, size_r <= CNT_W'(CAPACITY))
  // A successful insert grows the list by exactly one.
  `ASSERT_NEXT(a_ins_grows, clk, rst_n, cmd.exec && do_ins, size_r == $past(size_r) + CNT_W'(1))

endmodule

`default_nettype wire

// File: rtl/core/positional_list_engine_top.sv
// Bounded ordered list of up to 64 words of 16 bits. Each command transaction
// inserts a word at a position, at the head or at the tail, or removes the
// word at a position, at the head or at the tail; entries behind that place
// move by one cell, all cells at once. Every command returns one result
// transaction with a status, the removed word (zero unless a removal
// succeeded) and the element count afterwards. A bad position, a removal from
// an empty list or an insert into a full list is reported and leaves the list
// as it was; unused mode codes change nothing and report ok. Each command
// is first captured and then applied by the parallel shift of the cell
// chain, and a new command is taken only after the previous one has been
// applied. A waiting result holds the block in its execute step only
// when the next result is ready before the previous one has been taken.
`default_nettype none

module positional_list_engine_top
  import ple_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Command channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [2:0] mode, [9:3] position, [25:10] payload
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // [1:0] status, [17:2] removed_value,
                                       // [24:18] element_count
);

  ple_cmd_t             cmd;
  logic [STATUS_W-1:0]  status;
  logic [WORD_W-1:0]    removed_value;
  logic [CNT_W-1:0]     element_count;

  ple_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  ple_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .mode          (in_tdata[2:0]),
    .position      (in_tdata[9:3]),
    .payload       (in_tdata[25:10]),
    .status        (status),
    .removed_value (removed_value),
    .element_count (element_count)
  );

  // Pack the result fields, lowest field first.
  assign out_tdata = {7'd0, element_count, removed_value, status};

endmodule

`default_nettype wire
